// ----- src/gpm_pkg.sv -----
package gpm_pkg;

    localparam int PATTERN_ELEMENTS = 32;
    localparam int CNT_W            = $clog2(PATTERN_ELEMENTS + 1);
    localparam int EIDX_W           = $clog2(PATTERN_ELEMENTS);
    localparam int CLASS_W          = 128;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 8;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] LOW7      = 8'h7F;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_SUBJECT = 2'd2,
        OP_END     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        BR_OUTSIDE,
        BR_INSIDE,
        BR_RANGE_END
    } t_bracket;

    typedef logic [PATTERN_ELEMENTS:0]   t_act;
    typedef logic [PATTERN_ELEMENTS-1:0] t_elem;
    typedef logic [CLASS_W-1:0]          t_row;
    typedef t_row                        t_class_arr [PATTERN_ELEMENTS];

    // propagate active positions through runs of star elements with one add
    function automatic t_act close_stars(t_act a, t_elem star);
        t_act s;
        t_act x;
        begin
            s = {1'b0, star};
            x = a & s;
            return a | ((s + x) ^ s);
        end
    endfunction

endpackage

// ----- src/glob_pattern_matcher.sv -----
// Shell glob matcher on a stream. Each input transaction carries an op and a byte: clear
// pattern, append pattern byte, subject byte, or end of subject (subject byte zero also ends
// the subject). Pattern bytes compile into up to 32 elements: literal (low 7 bits), '?',
// '*', and bracket classes of bytes and ranges with no negation. Subject bytes update every
// active position at once, so one transaction is taken per cycle unless the input stalls; an
// end of subject passes through the input register and then the result register. One result
// transaction leaves per end of subject: bit 0 matched, bit 1 pattern overflow. Output
// backpressure stalls the input only when a finished result is still waiting and another end
// of subject sits in the input register.
module glob_pattern_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // op [1:0], data_byte [9:2], zero fill above
    input  logic [gpm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // matched [0], pattern_overflow [1], zero fill above
    output logic [gpm_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import gpm_pkg::*;

    // input register
    logic                r_in_v;
    t_op                 r_op;
    logic [7:0]          r_byte;

    // pattern and matcher state
    t_class_arr          r_class, n_class;
    t_elem               r_any, n_any;
    t_elem               r_star, n_star;
    logic [CNT_W-1:0]    r_count, n_count;
    t_bracket            r_br, n_br;
    logic [7:0]          r_prior, n_prior;
    t_act                r_act, n_act;
    logic                r_ovf, n_ovf;

    // result register
    logic                r_out_v;
    logic                r_match, r_res_ovf;

    logic                is_result;
    logic                adv;
    t_act                closed_now, step_next;
    logic [EIDX_W-1:0]   cur_e, new_e;
    logic [6:0]          lo7, hi7;
    t_row                range_mask;

    assign is_result  = (r_op == OP_END) || ((r_op == OP_SUBJECT) && (r_byte == 8'd0));
    assign adv        = r_in_v && (!is_result || !r_out_v || i_m_tready);
    assign o_s_tready = !r_in_v || adv;

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {{(M_TDATA_W - 2){1'b0}}, r_res_ovf, r_match};

    gpm_step u_step (
        .i_act    (r_act),
        .i_star   (r_star),
        .i_any    (r_any),
        .i_class  (r_class),
        .i_count  (r_count),
        .i_br     (r_br),
        .i_byte   (r_byte),
        .o_closed (closed_now),
        .o_next   (step_next)
    );

    // element being filled, and the slot a new element takes
    assign cur_e = (r_count == '0) ? '0 : EIDX_W'(r_count - CNT_W'(1));
    assign new_e = EIDX_W'(r_count);

    // inclusive range low..high of the low 7 bits
    assign lo7 = r_prior[6:0];
    assign hi7 = r_byte[6:0];
    assign range_mask = (lo7 > hi7) ? '0
        : (({CLASS_W{1'b1}} << lo7) & ({CLASS_W{1'b1}} >> (7'd127 - hi7)));

    always_comb begin
        n_class = r_class;
        n_any   = r_any;
        n_star  = r_star;
        n_count = r_count;
        n_br    = r_br;
        n_prior = r_prior;
        n_act   = r_act;
        n_ovf   = r_ovf;
        if (adv) begin
            unique case (r_op)
                OP_CLEAR: begin
                    for (int i = 0; i < PATTERN_ELEMENTS; i++) begin
                        n_class[i] = '0;
                    end
                    n_any   = '0;
                    n_star  = '0;
                    n_count = '0;
                    n_br    = BR_OUTSIDE;
                    n_prior = '0;
                    n_ovf   = 1'b0;
                    n_act   = t_act'(1);
                end
                OP_APPEND: begin
                    if (!r_ovf && (r_byte != 8'd0)) begin
                        unique case (r_br)
                            BR_OUTSIDE: begin
                                if (r_count >= CNT_W'(PATTERN_ELEMENTS)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_count = r_count + CNT_W'(1);
                                    if (r_byte == CH_LBRACK) begin
                                        n_br = BR_INSIDE;
                                    end else if (r_byte == CH_STAR) begin
                                        n_star[new_e] = 1'b1;
                                    end else if (r_byte == CH_QUEST) begin
                                        n_any[new_e] = 1'b1;
                                    end else begin
                                        n_class[new_e] = r_class[new_e]
                                            | (t_row'(1) << r_byte[6:0]);
                                    end
                                end
                                n_prior = r_byte;
                            end
                            BR_INSIDE: begin
                                if (r_byte == CH_RBRACK) begin
                                    n_br    = BR_OUTSIDE;
                                    n_prior = r_byte;
                                end else if (r_byte == CH_DASH) begin
                                    n_br = BR_RANGE_END;
                                end else begin
                                    n_class[cur_e] = r_class[cur_e]
                                        | (t_row'(1) << r_byte[6:0]);
                                    n_prior = r_byte;
                                end
                            end
                            default: begin
                                n_class[cur_e] = r_class[cur_e] | range_mask;
                                n_br    = BR_INSIDE;
                                n_prior = r_byte;
                            end
                        endcase
                    end
                end
                OP_SUBJECT: begin
                    if (r_byte == 8'd0) begin
                        n_act = t_act'(1);
                    end else begin
                        n_act = step_next;
                    end
                end
                default: begin
                    n_act = t_act'(1);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int i = 0; i < PATTERN_ELEMENTS; i++) begin
                r_class[i] <= '0;
            end
            r_any   <= '0;
            r_star  <= '0;
            r_count <= '0;
            r_br    <= BR_OUTSIDE;
            r_prior <= '0;
            r_act   <= t_act'(1);
            r_ovf   <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_v <= i_s_tvalid;
            end
            // result register drains on the output transaction
            if (adv && is_result) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
            r_class <= n_class;
            r_any   <= n_any;
            r_star  <= n_star;
            r_count <= n_count;
            r_br    <= n_br;
            r_prior <= n_prior;
            r_act   <= n_act;
            r_ovf   <= n_ovf;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op   <= t_op'(i_s_tdata[1:0]);
            r_byte <= i_s_tdata[9:2];
        end
        if (adv && is_result) begin
            r_match   <= closed_now[r_count];
            r_res_ovf <= r_ovf;
        end
    end

endmodule

// ----- src/gpm_step.sv -----
module gpm_step (
    input  gpm_pkg::t_act                  i_act,
    input  gpm_pkg::t_elem                 i_star,
    input  gpm_pkg::t_elem                 i_any,
    input  gpm_pkg::t_class_arr            i_class,
    input  logic [gpm_pkg::CNT_W-1:0]      i_count,
    input  gpm_pkg::t_bracket              i_br,
    input  logic [7:0]                     i_byte,
    output gpm_pkg::t_act                  o_closed,
    output gpm_pkg::t_act                  o_next
);
    import gpm_pkg::*;

    t_act  closed;
    t_act  nx;
    t_elem takes;

    assign closed   = close_stars(i_act, i_star);
    assign o_closed = closed;

    always_comb begin
        nx = '0;
        for (int i = 0; i < PATTERN_ELEMENTS; i++) begin
            takes[i] = (CNT_W'(i) < i_count)
                && !((CNT_W'(i + 1) == i_count) && (i_br != BR_OUTSIDE))
                && (i_any[i] || (!i_byte[7] && i_class[i][i_byte[6:0]]));
            if (closed[i] && i_star[i]) begin
                nx[i] = 1'b1;
            end else if (closed[i] && takes[i]) begin
                nx[i + 1] = 1'b1;
            end
        end
    end

    assign o_next = close_stars(nx, i_star);

endmodule

// ----- src/gpm_checker.sv -----
module gpm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [gpm_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import gpm_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // no result leaves right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty result register");

    // fill bits of the result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[M_TDATA_W-1:2] == '0))
        else $error("nonzero fill in result");

endmodule

bind glob_pattern_matcher gpm_checker u_gpm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
